@@ hdl/pgs_pkg.sv @@
`timescale 1ns / 1ps

package pgs_pkg;

   localparam int MAX_SIDE_DEFAULT   = 256;
   localparam int LEVEL_BITS_DEFAULT = 24;

   // fixed field widths
   localparam int FUNC_BITS      = 3;
   localparam int COORD_BITS     = 8;
   localparam int DEPOSIT_BITS   = 24;
   localparam int OUT_LEVEL_BITS = 24;
   localparam int SIZE_REG_BITS  = 9;
   localparam int RATE_BITS      = 16;
   localparam int CFG_LEVEL_BITS = 24;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 24;

   // evaporation factor is one minus the Q0.16 rate
   localparam int FRAC_BITS   = 16;
   localparam int FACTOR_BITS = 17;
   localparam logic [FACTOR_BITS-1:0] RATE_ONE = 17'h10000;

   typedef enum logic [FUNC_BITS-1:0] {
      OP_READ  = 3'd0,
      OP_ADD   = 3'd1,
      OP_EVAP  = 3'd2,
      OP_CLEAR = 3'd3,
      OP_MAX   = 3'd4
   } op_type;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_WIDTH       = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_HEIGHT      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EVAPORATION_RATE = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INITIAL_LEVEL    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MINIMUM_LEVEL    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAXIMUM_LEVEL    = 3'd5;

   typedef struct packed {
      logic [SIZE_REG_BITS-1:0]  grid_width;
      logic [SIZE_REG_BITS-1:0]  grid_height;
      logic [RATE_BITS-1:0]      evaporation_rate;
      logic [CFG_LEVEL_BITS-1:0] initial_level;
      logic [CFG_LEVEL_BITS-1:0] minimum_level;
      logic [CFG_LEVEL_BITS-1:0] maximum_level;
   } csr_type;

   localparam csr_type CSR_RESET = '{
      grid_width:       9'd256,
      grid_height:      9'd256,
      evaporation_rate: 16'd6554,
      initial_level:    24'd65536,
      minimum_level:    24'd655,
      maximum_level:    24'd16777215
   };

   // sequencer to datapath
   typedef struct packed {
      logic                    start;
      logic                    issue;
      logic                    last;
      op_type                  op;
      logic [DEPOSIT_BITS-1:0] deposit;
   } dp_ctl_type;

   // datapath to sequencer
   typedef struct packed {
      logic                      done;
      logic [OUT_LEVEL_BITS-1:0] level;
   } dp_sts_type;

endpackage

@@ hdl/pgs_if.sv @@
`timescale 1ns / 1ps

interface pgs_req_if;
   logic                               valid;
   logic                               ready;
   logic [pgs_pkg::FUNC_BITS-1:0]      func;
   logic [pgs_pkg::COORD_BITS-1:0]     column;
   logic [pgs_pkg::COORD_BITS-1:0]     row;
   logic [pgs_pkg::DEPOSIT_BITS-1:0]   deposit;

   modport source (output valid, func, column, row, deposit, input ready);
   modport sink   (input valid, func, column, row, deposit, output ready);
endinterface

interface pgs_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [pgs_pkg::OUT_LEVEL_BITS-1:0] level;
   logic                               out_of_grid;

   modport source (output valid, level, out_of_grid, input ready);
   modport sink   (input valid, level, out_of_grid, output ready);
endinterface

@@ hdl/pgs_datapath.sv @@
`timescale 1ns / 1ps

module pgs_datapath #(
   parameter int MAX_SIDE   = pgs_pkg::MAX_SIDE_DEFAULT,
   parameter int LEVEL_BITS = pgs_pkg::LEVEL_BITS_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  pgs_pkg::csr_type                            csr,
   input  pgs_pkg::dp_ctl_type                         ctl,
   input  logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]        cell_addr,
   output pgs_pkg::dp_sts_type                         sts
);

   localparam int CELLS     = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_BITS = $clog2(CELLS);
   localparam int VAL_BITS  = LEVEL_BITS + pgs_pkg::FACTOR_BITS;
   localparam logic [VAL_BITS-1:0] LEVEL_MASK =
      {{(VAL_BITS-LEVEL_BITS){1'b0}}, {LEVEL_BITS{1'b1}}};

   logic [LEVEL_BITS-1:0] cell_mem [CELLS];

   logic [LEVEL_BITS-1:0]            rd_data_ff;
   logic                             v1_ff, v2_ff, done_ff;
   logic                             last1_ff, last2_ff;
   logic [ADDR_BITS-1:0]             a1_ff, a2_ff;
   logic [VAL_BITS-1:0]              val2_in, val2_ff;
   logic [LEVEL_BITS-1:0]            best_ff, level_ff;
   logic [pgs_pkg::FACTOR_BITS-1:0]  factor;
   logic [VAL_BITS-1:0]              clamp_val;
   logic [LEVEL_BITS-1:0]            fin_level;
   logic                             wr_stage2, wr_en;
   logic [ADDR_BITS-1:0]             wr_addr;
   logic [LEVEL_BITS-1:0]            wr_data;

   assign factor = pgs_pkg::RATE_ONE - pgs_pkg::FACTOR_BITS'(csr.evaporation_rate);

   // single write port, single registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cell_mem[wr_addr] <= wr_data;
      end
      if (ctl.issue) begin
         rd_data_ff <= cell_mem[cell_addr];
      end
   end

   // stage 1: shared add or multiply on the cell just read
   always_comb begin
      case (ctl.op)
         pgs_pkg::OP_ADD:  val2_in = VAL_BITS'(rd_data_ff) + VAL_BITS'(ctl.deposit);
         pgs_pkg::OP_EVAP: val2_in = VAL_BITS'(rd_data_ff) * VAL_BITS'(factor);
         default:          val2_in = VAL_BITS'(rd_data_ff);
      endcase
   end

   // stage 2: clamp and write back
   always_comb begin
      clamp_val = val2_ff;
      wr_stage2 = 1'b0;
      case (ctl.op)
         pgs_pkg::OP_ADD: begin
            if (val2_ff > VAL_BITS'(csr.maximum_level)) begin
               clamp_val = VAL_BITS'(csr.maximum_level);
            end
            if (clamp_val > LEVEL_MASK) begin
               clamp_val = LEVEL_MASK;
            end
            wr_stage2 = v2_ff;
         end
         pgs_pkg::OP_EVAP: begin
            clamp_val = val2_ff >> pgs_pkg::FRAC_BITS;
            if (clamp_val < VAL_BITS'(csr.minimum_level)) begin
               clamp_val = VAL_BITS'(csr.minimum_level);
            end
            wr_stage2 = v2_ff;
         end
         default: ;
      endcase
   end

   assign fin_level = clamp_val[LEVEL_BITS-1:0];

   // clear writes straight from the issue slot, no read needed
   always_comb begin
      if (ctl.op == pgs_pkg::OP_CLEAR) begin
         wr_en   = ctl.issue;
         wr_addr = cell_addr;
         wr_data = LEVEL_BITS'(csr.initial_level);
      end else begin
         wr_en   = wr_stage2;
         wr_addr = a2_ff;
         wr_data = fin_level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff   <= ctl.issue;
         v2_ff   <= v1_ff;
         done_ff <= v2_ff && last2_ff;
      end
   end

   always_ff @(posedge clock) begin
      last1_ff <= ctl.last;
      a1_ff    <= cell_addr;
      last2_ff <= last1_ff;
      a2_ff    <= a1_ff;
      val2_ff  <= val2_in;
      if (v2_ff) begin
         level_ff <= fin_level;
      end
      if (ctl.start) begin
         best_ff <= '0;
      end else if (v1_ff && ctl.op == pgs_pkg::OP_MAX && rd_data_ff > best_ff) begin
         best_ff <= rd_data_ff;
      end
   end

   always_comb begin
      sts.done = done_ff;
      case (ctl.op) inside
         pgs_pkg::OP_MAX:                  sts.level = pgs_pkg::OUT_LEVEL_BITS'(best_ff);
         pgs_pkg::OP_READ, pgs_pkg::OP_ADD: sts.level = pgs_pkg::OUT_LEVEL_BITS'(level_ff);
         default:                          sts.level = '0;
      endcase
   end

   // the last cell of an item has left the pipe when done rises
   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !v1_ff && !v2_ff)
      else $error("pgs_datapath: done with cells still in flight");

   // a write-back never hits the cell being fetched in the same cycle
   assert property (@(posedge clock) disable iff (reset)
      (wr_stage2 && ctl.issue) |-> a2_ff != cell_addr)
      else $error("pgs_datapath: write-back collides with fetch");

endmodule

@@ hdl/pgs_seq.sv @@
`timescale 1ns / 1ps

module pgs_seq #(
   parameter int MAX_SIDE = pgs_pkg::MAX_SIDE_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   pgs_req_if.sink                              req_ch,
   pgs_rsp_if.source                            rsp_ch,
   input  pgs_pkg::csr_type                     csr,
   input  pgs_pkg::dp_sts_type                  dp_sts,
   output pgs_pkg::dp_ctl_type                  dp_ctl,
   output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] cell_addr
);

   localparam int CELLS      = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_BITS  = $clog2(CELLS);
   localparam int COUNT_BITS = $clog2(CELLS + 1);
   localparam int SIDE_BITS  = $clog2(MAX_SIDE + 1);
   localparam int RPROD_BITS = SIDE_BITS + pgs_pkg::COORD_BITS;
   localparam int IDX_BITS   = (ADDR_BITS > RPROD_BITS + 1) ? ADDR_BITS : RPROD_BITS + 1;
   localparam int GPROD_BITS = 2 * SIDE_BITS;
   localparam int CMP_BITS   = (SIDE_BITS > pgs_pkg::COORD_BITS) ? SIDE_BITS + 1
                                                                 : pgs_pkg::COORD_BITS + 1;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_ISSUE  = 4'b0010,
      S_WAIT   = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   function automatic logic [SIDE_BITS-1:0] used_side(
      input logic [pgs_pkg::SIZE_REG_BITS-1:0] v
   );
      logic [SIDE_BITS-1:0] r;
      if (v == '0) begin
         r = SIDE_BITS'(1);
      end else if (int'(v) > MAX_SIDE) begin
         r = SIDE_BITS'(MAX_SIDE);
      end else begin
         r = SIDE_BITS'(v);
      end
      return r;
   endfunction

   state_type                           state_in, state_ff;
   pgs_pkg::op_type                     op_in, op_ff;
   logic                                point_in, point_ff;
   logic [COUNT_BITS-1:0]               cnt_in, cnt_ff;
   logic [COUNT_BITS-1:0]               last_idx_in, last_idx_ff;
   logic [pgs_pkg::DEPOSIT_BITS-1:0]    dep_in, dep_ff;
   logic [pgs_pkg::OUT_LEVEL_BITS-1:0]  res_level_in, res_level_ff;
   logic                                res_flag_in, res_flag_ff;
   logic                                rsp_valid_in, rsp_valid_ff;
   logic [pgs_pkg::OUT_LEVEL_BITS-1:0]  rsp_level_in, rsp_level_ff;
   logic                                rsp_flag_in, rsp_flag_ff;

   logic [SIDE_BITS-1:0]  w_used, h_used;
   logic [RPROD_BITS-1:0] row_prod;
   logic [IDX_BITS-1:0]   idx;
   logic [GPROD_BITS-1:0] grid_prod;
   logic                  oob;
   logic                  start, issue, last;

   assign w_used    = used_side(csr.grid_width);
   assign h_used    = used_side(csr.grid_height);
   assign row_prod  = RPROD_BITS'(w_used) * RPROD_BITS'(req_ch.row);
   assign idx       = IDX_BITS'(row_prod) + IDX_BITS'(req_ch.column);
   assign grid_prod = GPROD_BITS'(w_used) * GPROD_BITS'(h_used);
   assign oob       = (CMP_BITS'(req_ch.column) >= CMP_BITS'(w_used))
                   || (CMP_BITS'(req_ch.row) >= CMP_BITS'(h_used));

   assign req_ch.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      point_in     = point_ff;
      cnt_in       = cnt_ff;
      last_idx_in  = last_idx_ff;
      dep_in       = dep_ff;
      res_level_in = res_level_ff;
      res_flag_in  = res_flag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_level_in = rsp_level_ff;
      rsp_flag_in  = rsp_flag_ff;
      start        = 1'b0;
      issue        = 1'b0;
      last         = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               start        = 1'b1;
               dep_in       = req_ch.deposit;
               cnt_in       = '0;
               last_idx_in  = grid_prod[COUNT_BITS-1:0] - COUNT_BITS'(1);
               point_in     = 1'b0;
               res_level_in = '0;
               res_flag_in  = 1'b0;
               unique case (req_ch.func) inside
                  pgs_pkg::OP_READ, pgs_pkg::OP_ADD: begin
                     op_in = pgs_pkg::op_type'(req_ch.func);
                     if (oob) begin
                        res_flag_in = 1'b1;
                        state_in    = S_FINISH;
                     end else begin
                        point_in = 1'b1;
                        cnt_in   = COUNT_BITS'(idx[ADDR_BITS-1:0]);
                        state_in = S_ISSUE;
                     end
                  end
                  pgs_pkg::OP_EVAP, pgs_pkg::OP_CLEAR, pgs_pkg::OP_MAX: begin
                     op_in    = pgs_pkg::op_type'(req_ch.func);
                     state_in = S_ISSUE;
                  end
                  default: state_in = S_FINISH;
               endcase
            end
         end
         S_ISSUE: begin
            // one cell per cycle into the datapath
            issue = 1'b1;
            last  = point_ff || (cnt_ff == last_idx_ff);
            if (last) begin
               state_in = S_WAIT;
            end else begin
               cnt_in = cnt_ff + COUNT_BITS'(1);
            end
         end
         S_WAIT: begin
            if (dp_sts.done) begin
               res_level_in = dp_sts.level;
               state_in     = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = res_level_ff;
               rsp_flag_in  = res_flag_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      point_ff     <= point_in;
      cnt_ff       <= cnt_in;
      last_idx_ff  <= last_idx_in;
      dep_ff       <= dep_in;
      res_level_ff <= res_level_in;
      res_flag_ff  <= res_flag_in;
      rsp_level_ff <= rsp_level_in;
      rsp_flag_ff  <= rsp_flag_in;
   end

   always_comb begin
      dp_ctl.start   = start;
      dp_ctl.issue   = issue;
      dp_ctl.last    = last;
      dp_ctl.op      = op_ff;
      dp_ctl.deposit = dep_ff;
   end

   assign cell_addr          = cnt_ff[ADDR_BITS-1:0];
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.level       = rsp_level_ff;
   assign rsp_ch.out_of_grid = rsp_flag_ff;

   // the datapath only finishes an item the sequencer is waiting on
   assert property (@(posedge clock) disable iff (reset)
      dp_sts.done |-> state_ff == S_WAIT)
      else $error("pgs_seq: datapath done outside wait");

endmodule

@@ hdl/pheromone_grid_store_unit.sv @@
// Pheromone grid store: a grid of up to MAX_SIDE by MAX_SIDE unsigned Q8.16 levels held in
// one single-port-read, single-port-write memory, worked by one shared add/multiply and
// clamp unit under a small sequencer. The block takes one item at a time. A read or add
// passes through fetch, compute, clamp and write-back, then result load; evaporate, clear
// and max query sweep the grid in use at one cell per cycle through the memory read port.
// Coordinates outside the grid and unused codes go straight to the result without using
// the datapath. A finished result waits in the output register while the next item is
// accepted. The cells are not initialized at reset: issue a clear before reading, adding,
// evaporating or querying, and again after enlarging the grid. Configuration must be
// written only while the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps

module pheromone_grid_store_unit #(
   parameter int MAX_SIDE   = pgs_pkg::MAX_SIDE_DEFAULT,
   parameter int LEVEL_BITS = pgs_pkg::LEVEL_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   pgs_req_if.sink                              req_ch,
   pgs_rsp_if.source                            rsp_ch,
   input  logic                                 csr_we,
   input  logic [pgs_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [pgs_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   localparam int ADDR_BITS = $clog2(MAX_SIDE * MAX_SIDE);

   pgs_pkg::csr_type     csr_in, csr_ff;
   pgs_pkg::dp_ctl_type  dp_ctl;
   pgs_pkg::dp_sts_type  dp_sts;
   logic [ADDR_BITS-1:0] cell_addr;

   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         unique case (csr_index)
            pgs_pkg::CSR_GRID_WIDTH:
               csr_in.grid_width = csr_data[pgs_pkg::SIZE_REG_BITS-1:0];
            pgs_pkg::CSR_GRID_HEIGHT:
               csr_in.grid_height = csr_data[pgs_pkg::SIZE_REG_BITS-1:0];
            pgs_pkg::CSR_EVAPORATION_RATE:
               csr_in.evaporation_rate = csr_data[pgs_pkg::RATE_BITS-1:0];
            pgs_pkg::CSR_INITIAL_LEVEL:
               csr_in.initial_level = csr_data[pgs_pkg::CFG_LEVEL_BITS-1:0];
            pgs_pkg::CSR_MINIMUM_LEVEL:
               csr_in.minimum_level = csr_data[pgs_pkg::CFG_LEVEL_BITS-1:0];
            pgs_pkg::CSR_MAXIMUM_LEVEL:
               csr_in.maximum_level = csr_data[pgs_pkg::CFG_LEVEL_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= pgs_pkg::CSR_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   pgs_seq #(
      .MAX_SIDE (MAX_SIDE)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr       (csr_ff),
      .dp_sts    (dp_sts),
      .dp_ctl    (dp_ctl),
      .cell_addr (cell_addr)
   );

   pgs_datapath #(
      .MAX_SIDE   (MAX_SIDE),
      .LEVEL_BITS (LEVEL_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .ctl       (dp_ctl),
      .cell_addr (cell_addr),
      .sts       (dp_sts)
   );

endmodule

@@ tb/sv/pgs_grid_checker.sv @@
`timescale 1ns / 1ps

module pgs_grid_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   pgs_req_if                                   req_ch,
   pgs_rsp_if                                   rsp_ch,
   input  logic                                 csr_we,
   input  logic [pgs_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [pgs_pkg::CSR_DATA_BITS-1:0]    csr_data,
   output int                                   error_count,
   output int                                   open_count
);
   import pgs_pkg::*;

   localparam int CELL_TOTAL = MAX_SIDE_DEFAULT * MAX_SIDE_DEFAULT;

   typedef struct packed {
      logic [OUT_LEVEL_BITS-1:0] level;
      logic                      out_of_grid;
   } grid_answer;

   csr_type                   regs;
   logic [OUT_LEVEL_BITS-1:0] cells [0:CELL_TOTAL-1];
   grid_answer                expected_answers [$];
   int                        errors;

   function automatic int unsigned side_in_use(input logic [SIZE_REG_BITS-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_SIDE_DEFAULT) return MAX_SIDE_DEFAULT;
      return 32'(v);
   endfunction

   // updates the shadow grid and returns what the block should answer
   function automatic grid_answer apply_op(input logic [FUNC_BITS-1:0]    func,
                                           input logic [COORD_BITS-1:0]   col,
                                           input logic [COORD_BITS-1:0]   row,
                                           input logic [DEPOSIT_BITS-1:0] dep);
      grid_answer                ans;
      int unsigned               w, h, span, idx, i;
      logic [OUT_LEVEL_BITS:0]   sum;
      logic [40:0]               prod;
      logic [OUT_LEVEL_BITS:0]   cut;
      logic [FACTOR_BITS-1:0]    factor;
      logic [OUT_LEVEL_BITS-1:0] best;
      ans = '0;
      w = side_in_use(regs.grid_width);
      h = side_in_use(regs.grid_height);
      span = w * h;
      case (func)
         OP_READ, OP_ADD: begin
            if (col >= w || row >= h) begin
               ans.out_of_grid = 1'b1;
            end else begin
               idx = col + w * row;
               sum = {1'b0, cells[idx]};
               if (func == OP_ADD) begin
                  sum = sum + dep;
                  if (sum > regs.maximum_level) sum = {1'b0, regs.maximum_level};
                  cells[idx] = sum[OUT_LEVEL_BITS-1:0];
               end
               ans.level = sum[OUT_LEVEL_BITS-1:0];
            end
         end
         OP_EVAP: begin
            factor = RATE_ONE - regs.evaporation_rate;
            for (i = 0; i < span; i++) begin
               prod = cells[i] * factor;
               cut = prod[40:FRAC_BITS];
               if (cut < regs.minimum_level) cut = {1'b0, regs.minimum_level};
               cells[i] = cut[OUT_LEVEL_BITS-1:0];
            end
         end
         OP_CLEAR: begin
            for (i = 0; i < span; i++) cells[i] = regs.initial_level;
         end
         OP_MAX: begin
            best = '0;
            for (i = 0; i < span; i++) if (cells[i] > best) best = cells[i];
            ans.level = best;
         end
         default: begin
         end
      endcase
      return ans;
   endfunction

   always @(posedge clock) begin
      grid_answer want;
      if (reset) begin
         regs = CSR_RESET;
         expected_answers.delete();
         errors = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_GRID_WIDTH:       regs.grid_width       = csr_data[SIZE_REG_BITS-1:0];
               CSR_GRID_HEIGHT:      regs.grid_height      = csr_data[SIZE_REG_BITS-1:0];
               CSR_EVAPORATION_RATE: regs.evaporation_rate = csr_data[RATE_BITS-1:0];
               CSR_INITIAL_LEVEL:    regs.initial_level    = csr_data;
               CSR_MINIMUM_LEVEL:    regs.minimum_level    = csr_data;
               CSR_MAXIMUM_LEVEL:    regs.maximum_level    = csr_data;
               default: begin
               end
            endcase
         end
         // compare before predicting so a fresh item never meets its own result
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_answers.size() == 0) begin
               $error("result item with nothing expected: level %0d, out_of_grid %0d",
                      rsp_ch.level, rsp_ch.out_of_grid);
               errors++;
            end else begin
               want = expected_answers.pop_front();
               if (rsp_ch.level !== want.level) begin
                  $error("level: expected %0d, actual %0d", want.level, rsp_ch.level);
                  errors++;
               end
               if (rsp_ch.out_of_grid !== want.out_of_grid) begin
                  $error("out_of_grid: expected %0d, actual %0d",
                         want.out_of_grid, rsp_ch.out_of_grid);
                  errors++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            expected_answers = {expected_answers,
                                apply_op(req_ch.func, req_ch.column, req_ch.row,
                                         req_ch.deposit)};
      end
      error_count <= errors;
      open_count  <= expected_answers.size();
   end

endmodule

@@ tb/sv/tb_pheromone_grid_store_unit.sv @@
`timescale 1ns / 1ps

module tb_pheromone_grid_store_unit;
   import pgs_pkg::*;

   localparam int ITEM_TARGET = 1950;
   localparam int QUIET_LIMIT = 300000;
   localparam int HOLD_CYCLES = 400;
   localparam int IDLE_PCT    = 30;
   localparam int SPAN_LIMIT  = 4096;

   logic                      clock;
   logic                      reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;
   int                        fail_total;
   int                        open_total;

   pgs_req_if req_if ();
   pgs_rsp_if rsp_if ();

   pheromone_grid_store_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   pgs_grid_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .error_count (fail_total),
      .open_count  (open_total)
   );

   // stimulus bookkeeping: effective grid and how far clears have written
   int eff_w = MAX_SIDE_DEFAULT;
   int eff_h = MAX_SIDE_DEFAULT;
   int cleared_span = 0;
   int items_sent = 0;
   int settings_used = 1;
   int op_tally [OP_READ:OP_MAX];
   int unused_codes = 0;
   bit steady = 1'b0;
   bit hold_request = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   task automatic offer_item(input logic [FUNC_BITS-1:0]    func,
                             input logic [COORD_BITS-1:0]   col,
                             input logic [COORD_BITS-1:0]   row,
                             input logic [DEPOSIT_BITS-1:0] dep);
      @(negedge clock);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.func    <= func;
      req_if.column  <= col;
      req_if.row     <= row;
      req_if.deposit <= dep;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      items_sent++;
      if (func > OP_MAX) unused_codes++;
      else op_tally[func]++;
      if (func == OP_CLEAR && eff_w * eff_h > cleared_span) cleared_span = eff_w * eff_h;
   endtask

   // drop valid and let every outstanding result drain
   task automatic settle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (open_total != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0]  value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic configure(input int w_raw, input int h_raw, input logic [RATE_BITS-1:0] rate,
                            input logic [CFG_LEVEL_BITS-1:0] start_lvl,
                            input logic [CFG_LEVEL_BITS-1:0] floor_lvl,
                            input logic [CFG_LEVEL_BITS-1:0] ceil_lvl);
      settle();
      write_reg(CSR_GRID_WIDTH, CSR_DATA_BITS'(w_raw));
      write_reg(CSR_GRID_HEIGHT, CSR_DATA_BITS'(h_raw));
      write_reg(CSR_EVAPORATION_RATE, CSR_DATA_BITS'(rate));
      write_reg(CSR_INITIAL_LEVEL, start_lvl);
      write_reg(CSR_MINIMUM_LEVEL, floor_lvl);
      write_reg(CSR_MAXIMUM_LEVEL, ceil_lvl);
      eff_w = (w_raw == 0) ? 1 : ((w_raw > MAX_SIDE_DEFAULT) ? MAX_SIDE_DEFAULT : w_raw);
      eff_h = (h_raw == 0) ? 1 : ((h_raw > MAX_SIDE_DEFAULT) ? MAX_SIDE_DEFAULT : h_raw);
      settings_used++;
      // cells beyond the cleared area hold garbage, so write them first
      if (eff_w * eff_h > cleared_span) offer_item(OP_CLEAR, '0, '0, '0);
   endtask

   function automatic logic [CFG_LEVEL_BITS-1:0] pick_level();
      case ($urandom_range(4))
         0:       return '0;
         1:       return '1;
         2:       return CFG_LEVEL_BITS'($urandom_range(65535));
         default: return CFG_LEVEL_BITS'($urandom);
      endcase
   endfunction

   task automatic random_item();
      int                        pick;
      logic [FUNC_BITS-1:0]      f;
      logic [COORD_BITS-1:0]     c, r;
      logic [DEPOSIT_BITS-1:0]   d;
      pick = $urandom_range(99);
      if (pick < 40)      f = OP_READ;
      else if (pick < 76) f = OP_ADD;
      else if (pick < 84) f = OP_MAX;
      else if (pick < 91) f = OP_EVAP;
      else if (pick < 95) f = OP_CLEAR;
      else                f = FUNC_BITS'($urandom_range(7, OP_MAX + 1));
      if (eff_w * eff_h > SPAN_LIMIT && (f == OP_MAX || f == OP_EVAP || f == OP_CLEAR))
         f = OP_READ;
      if ($urandom_range(99) < 85) begin
         c = COORD_BITS'($urandom_range(eff_w - 1));
         r = COORD_BITS'($urandom_range(eff_h - 1));
      end else begin
         c = COORD_BITS'($urandom);
         r = COORD_BITS'($urandom);
      end
      case ($urandom_range(3))
         0:       d = DEPOSIT_BITS'($urandom_range(255));
         1:       d = DEPOSIT_BITS'($urandom_range(65535));
         2:       d = '1;
         default: d = DEPOSIT_BITS'($urandom);
      endcase
      offer_item(f, c, r, d);
   endtask

   initial begin
      int phase, n, count, w_raw, h_raw;
      logic [RATE_BITS-1:0] rate;
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      req_if.valid   = 1'b0;
      req_if.func    = '0;
      req_if.column  = '0;
      req_if.row     = '0;
      req_if.deposit = '0;
      foreach (op_tally[k]) op_tally[k] = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // full grid at reset settings: corners, saturation, sweeps, unused codes
      offer_item(OP_CLEAR, '0, '0, '0);
      offer_item(OP_READ, 8'd0, 8'd0, '0);
      offer_item(OP_READ, 8'd255, 8'd255, '0);
      offer_item(OP_ADD, 8'd255, 8'd255, '1);
      offer_item(OP_ADD, 8'd0, 8'd0, '0);
      offer_item(OP_MAX, '0, '0, '0);
      offer_item(OP_EVAP, '0, '0, '0);
      offer_item(OP_READ, 8'd255, 8'd255, '0);
      offer_item(3'd5, 8'd17, 8'd3, 24'h123456);
      offer_item(3'd6, '1, '1, '1);
      offer_item(3'd7, '0, '0, '0);

      // small grid, zero rate and floor, low ceiling, coordinates just outside
      configure(5, 3, 16'd0, 24'd0, 24'd0, 24'd1000);
      offer_item(OP_CLEAR, '0, '0, '0);
      offer_item(OP_ADD, 8'd4, 8'd2, 24'd2000);
      offer_item(OP_ADD, 8'd0, 8'd0, 24'd999);
      offer_item(OP_READ, 8'd5, 8'd0, '0);
      offer_item(OP_READ, 8'd0, 8'd3, '0);
      offer_item(OP_ADD, 8'd255, 8'd255, '1);
      offer_item(OP_EVAP, '0, '0, '0);
      offer_item(OP_MAX, '0, '0, '0);
      offer_item(OP_READ, 8'd4, 8'd2, '0);

      // zero width and oversize height, full rate, ceiling below floor, stale cells
      configure(0, 511, 16'hFFFF, '1, 24'd100, 24'd50);
      offer_item(OP_READ, 8'd0, 8'd255, '0);
      offer_item(OP_READ, 8'd1, 8'd0, '0);
      offer_item(OP_EVAP, '0, '0, '0);
      offer_item(OP_ADD, 8'd0, 8'd0, 24'd10);
      offer_item(OP_MAX, '0, '0, '0);
      offer_item(OP_CLEAR, '0, '0, '0);
      offer_item(OP_READ, 8'd0, 8'd128, '0);
      offer_item(OP_ADD, 8'd0, 8'd17, '1);

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(9))
            0: begin w_raw = MAX_SIDE_DEFAULT; h_raw = $urandom_range(4, 1); end
            1: begin w_raw = $urandom_range(4, 1); h_raw = MAX_SIDE_DEFAULT; end
            2: begin w_raw = 0; h_raw = $urandom_range(511, 257); end
            3: begin w_raw = $urandom_range(511, 257); h_raw = $urandom_range(2, 0); end
            default: begin w_raw = $urandom_range(16, 1); h_raw = $urandom_range(16, 1); end
         endcase
         case ($urandom_range(3))
            0:       rate = '0;
            1:       rate = '1;
            default: rate = RATE_BITS'($urandom);
         endcase
         configure(w_raw, h_raw, rate, pick_level(), pick_level(), pick_level());
         count = (phase == 3) ? 150 : $urandom_range(100, 50);
         for (n = 0; n < count; n++) begin
            random_item();
            if (n == 0) begin
               steady = (phase == 3);
               hold_request = (phase == 6);
            end
         end
         phase++;
      end

      settle();
      repeat (8) @(negedge clock);
      $display("ran %0d items over %0d grid settings: %0d reads, %0d adds, %0d evaporations,",
               items_sent, settings_used, op_tally[OP_READ], op_tally[OP_ADD],
               op_tally[OP_EVAP]);
      $display("  %0d clears, %0d max queries, %0d unused codes", op_tally[OP_CLEAR],
               op_tally[OP_MAX], unused_codes);
      if (fail_total == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
